[rtl/ics_pkg.sv]
// Shared types and constants for the inverse-CDF sampler.
// No dependencies; every other source file except ics_ram imports this package.
`default_nettype none

package ics_pkg;

  // Table depth default
  localparam int MAX_POINTS_DEF = 64;

  // Field widths
  localparam int IDX_W  = 6;
  localparam int EDGE_W = 32;
  localparam int CDF_W  = 32;
  localparam int UNI_W  = 31;
  localparam int PC_W   = 7;
  localparam int EPS_W  = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON     = 1'b1;
  localparam logic [PC_W-1:0]      POINT_COUNT_RST = 7'd64;
  localparam logic [EPS_W-1:0]     EPSILON_RST     = 16'd1;

  // Request codes
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  // Arithmetic widths: product of two 32-bit magnitudes, positive denominator
  localparam int PROD_W = 64;
  localparam int DEN_W  = 33;

  // One classified request in the queue
  typedef struct packed {
    logic                     is_sample;
    logic                     load_ok;
    logic [IDX_W-1:0]         point_index;
    logic signed [EDGE_W-1:0] bin_value;
    logic [CDF_W-1:0]         cdf_value;
    logic [UNI_W-1:0]         uniform;
  } item_t;

  // Configuration register set
  typedef struct packed {
    logic [PC_W-1:0]  point_count;
    logic [EPS_W-1:0] epsilon;
  } cfg_t;

endpackage

`default_nettype wire

[rtl/ics_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ics_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/ics_front.sv]
// Front end: accepts requests, classifies load versus sample, and queues them.
// Depends on ics_pkg.
`default_nettype none

module ics_front #(
  parameter int MAX_POINTS = ics_pkg::MAX_POINTS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              item_valid,
  output logic                                   item_stall,
  input  wire logic                              action,
  input  wire logic [ics_pkg::IDX_W-1:0]         point_index,
  input  wire logic signed [ics_pkg::EDGE_W-1:0] bin_value,
  input  wire logic [ics_pkg::CDF_W-1:0]         cdf_value,
  input  wire logic [ics_pkg::UNI_W-1:0]         uniform,
  output ics_pkg::item_t                         head,
  output logic                                   head_valid,
  input  wire logic                              pop
);

  import ics_pkg::*;

  item_t      slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  item_t      entry;

  assign item_stall = (count == 2'd2);
  assign push       = item_valid && !item_stall;
  assign head_valid = (count != 2'd0);
  assign head       = slot[rd_ptr];

  // Classify the incoming request
  always_comb begin
    entry.is_sample   = (action == ACT_SAMPLE);
    entry.load_ok     = (action == ACT_LOAD) && (int'(point_index) < MAX_POINTS);
    entry.point_index = point_index;
    entry.bin_value   = bin_value;
    entry.cdf_value   = cdf_value;
    entry.uniform     = uniform;
  end

  // Store the request
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/ics_div.sv]
// Restoring divider, one quotient bit per cycle, unsigned.
// Depends on ics_pkg.
`default_nettype none

module ics_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [ics_pkg::PROD_W-1:0] dividend,
  input  wire logic [ics_pkg::DEN_W-1:0]  divisor,
  output logic                            done,
  output logic [ics_pkg::PROD_W-1:0]      quotient
);

  import ics_pkg::*;

  localparam int CNT_W = $clog2(PROD_W);

  logic              busy;
  logic [CNT_W-1:0]  step;
  logic [PROD_W-1:0] dvd;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  dv;
  logic [DEN_W:0]    rem_sh;
  logic [DEN_W:0]    rem_sub;
  logic              ge;
  logic [DEN_W-1:0]  rem_next;

  // One restoring step
  always_comb begin
    rem_sh   = {rem, dvd[PROD_W-1]};
    ge       = (rem_sh >= {1'b0, dv});
    rem_sub  = rem_sh - {1'b0, dv};
    rem_next = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
  end

  assign quotient = dvd;

  // Datapath: quotient bits shift in behind the dividend
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dv  <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[PROD_W-2:0], ge};
      rem <= rem_next;
    end
  end

  // Step counter and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == CNT_W'(PROD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/ics_back.sv]
// Back end: table writes, interval search, interpolation and result register.
// Depends on ics_pkg, ics_ram and ics_div.
`default_nettype none

module ics_back #(
  parameter int MAX_POINTS = ics_pkg::MAX_POINTS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire ics_pkg::cfg_t                     cfg,
  input  wire ics_pkg::item_t                    head,
  input  wire logic                              head_valid,
  output logic                                   pop,
  output logic                                   result_valid,
  input  wire logic                              result_stall,
  output logic signed [ics_pkg::EDGE_W-1:0]      sample_value,
  output logic [ics_pkg::IDX_W-1:0]              interval_index,
  output logic                                   saturated
);

  import ics_pkg::*;

  localparam int AW   = $clog2(MAX_POINTS);
  localparam int KMAX = (MAX_POINTS < 64) ? MAX_POINTS : 64;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SEARCH = 4'd1;
  localparam logic [3:0] S_PICK   = 4'd2;
  localparam logic [3:0] S_RDA    = 4'd3;
  localparam logic [3:0] S_RDB    = 4'd4;
  localparam logic [3:0] S_RDC    = 4'd5;
  localparam logic [3:0] S_PREP   = 4'd6;
  localparam logic [3:0] S_MUL0   = 4'd7;
  localparam logic [3:0] S_MUL1   = 4'd8;
  localparam logic [3:0] S_DIV    = 4'd9;
  localparam logic [3:0] S_FIN    = 4'd10;
  localparam logic [3:0] S_DONE   = 4'd11;

  logic [3:0]               state;
  logic [PC_W-1:0]          t;
  logic [PC_W-1:0]          cnt;
  logic                     issue_v;
  logic [IDX_W-1:0]         j;
  logic [UNI_W-1:0]         u;
  logic [CDF_W-1:0]         c0;
  logic [CDF_W-1:0]         c1;
  logic signed [EDGE_W-1:0] e0;
  logic signed [EDGE_W-1:0] e1;
  logic                     neg;
  logic [31:0]              mag_diff;
  logic [31:0]              mag_du;
  logic [DEN_W-1:0]         den;
  logic [PROD_W-1:0]        prod;
  logic signed [EDGE_W-1:0] res;
  logic                     sat;
  logic                     div_start;
  logic                     div_done;
  logic [PROD_W-1:0]        quot;

  logic                     ram_we;
  logic [AW-1:0]            waddr;
  logic [AW-1:0]            raddr;
  logic [CDF_W-1:0]         cdf_rdata;
  logic [EDGE_W-1:0]        edge_rdata;
  logic [AW+IDX_W-1:0]      widx;
  logic [AW+PC_W-1:0]       t_ext;
  logic [AW+PC_W-1:0]       j_ext;
  logic [AW+PC_W-1:0]       j1_ext;
  logic [PC_W-1:0]          k;
  logic                     issue;
  logic [PC_W-1:0]          jm;
  logic [PC_W-1:0]          km2;
  logic [PC_W-1:0]          jc;
  logic                     out_free;

  logic signed [33:0]       d_full;
  logic                     d_pos;
  logic [32:0]              diff33;
  logic [32:0]              ndiff;
  logic [33:0]              du34;
  logic [33:0]              ndu;
  logic [47:0]              pp;
  logic                     q_big;
  logic signed [35:0]       sum36;
  logic                     over_hi;
  logic                     over_lo;

  // Points in use, clamped to the table
  always_comb begin
    if (cfg.point_count < PC_W'(2)) begin
      k = PC_W'(2);
    end else if (cfg.point_count > PC_W'(KMAX)) begin
      k = PC_W'(KMAX);
    end else begin
      k = cfg.point_count;
    end
  end

  // Table addressing
  assign widx   = {{AW{1'b0}}, head.point_index};
  assign waddr  = widx[AW-1:0];
  assign t_ext  = {{AW{1'b0}}, t};
  assign j_ext  = {{(AW+1){1'b0}}, j};
  assign j1_ext = j_ext + 1'b1;
  assign issue  = (t < k);

  assign pop      = (state == S_IDLE) && head_valid;
  assign ram_we   = pop && !head.is_sample && head.load_ok;
  assign out_free = !result_valid || !result_stall;

  always_comb begin
    unique case (state)
      S_SEARCH: raddr = issue ? t_ext[AW-1:0] : '0;
      S_RDA:    raddr = j_ext[AW-1:0];
      S_RDB:    raddr = j1_ext[AW-1:0];
      default:  raddr = '0;
    endcase
  end

  ics_ram #(.WIDTH(CDF_W), .DEPTH(MAX_POINTS)) u_cdf_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (head.cdf_value),
    .raddr (raddr),
    .rdata (cdf_rdata)
  );

  ics_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_POINTS)) u_edge_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (head.bin_value),
    .raddr (raddr),
    .rdata (edge_rdata)
  );

  // Interval pick: count minus one (zero when count is zero), clamped to k-2
  always_comb begin
    jm  = (cnt == '0) ? '0 : cnt - 1'b1;
    km2 = k - PC_W'(2);
    jc  = (jm > km2) ? km2 : jm;
  end

  // Denominator, edge span and offset into the interval
  always_comb begin
    d_full = $signed({2'b00, c1}) - $signed({2'b00, c0}) + $signed({18'd0, cfg.epsilon});
    d_pos  = !d_full[33] && (d_full != '0);
    diff33 = {e1[31], e1} - {e0[31], e0};
    ndiff  = -diff33;
    du34   = {3'b000, u} - {2'b00, c0};
    ndu    = -du34;
  end

  // Shared 32x16 partial product
  assign pp = mag_diff * ((state == S_MUL1) ? mag_du[31:16] : mag_du[15:0]);

  ics_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (den),
    .done     (div_done),
    .quotient (quot)
  );

  // Apply the quotient to the left edge and clamp
  always_comb begin
    q_big   = (|quot[PROD_W-1:35]) || (quot[34] && (|quot[33:0]));
    if (neg) begin
      sum36 = $signed({{4{e0[31]}}, e0}) - $signed({1'b0, quot[34:0]});
    end else begin
      sum36 = $signed({{4{e0[31]}}, e0}) + $signed({1'b0, quot[34:0]});
    end
    over_hi = (sum36 > 36'sh0_7FFF_FFFF);
    over_lo = (sum36 < -36'sh0_8000_0000);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issue_v   <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (pop && head.is_sample) begin
            u       <= head.uniform;
            t       <= '0;
            cnt     <= '0;
            issue_v <= 1'b0;
            state   <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (issue) begin
            t <= t + 1'b1;
          end
          issue_v <= issue;
          if (issue_v && ({1'b0, u} >= cdf_rdata)) begin
            cnt <= cnt + 1'b1;
          end
          if (!issue && !issue_v) begin
            state <= S_PICK;
          end
        end
        S_PICK: begin
          j     <= jc[IDX_W-1:0];
          state <= S_RDA;
        end
        S_RDA: begin
          state <= S_RDB;
        end
        S_RDB: begin
          c0    <= cdf_rdata;
          e0    <= edge_rdata;
          state <= S_RDC;
        end
        S_RDC: begin
          c1    <= cdf_rdata;
          e1    <= edge_rdata;
          state <= S_PREP;
        end
        S_PREP: begin
          neg      <= diff33[32] ^ du34[33];
          mag_diff <= diff33[32] ? ndiff[31:0] : diff33[31:0];
          mag_du   <= du34[33] ? ndu[31:0] : du34[31:0];
          den      <= d_full[DEN_W-1:0];
          if (d_pos) begin
            state <= S_MUL0;
          end else begin
            res   <= e0;
            sat   <= 1'b1;
            state <= S_DONE;
          end
        end
        S_MUL0: begin
          prod  <= {16'd0, pp};
          state <= S_MUL1;
        end
        S_MUL1: begin
          prod      <= prod + {pp, 16'd0};
          div_start <= 1'b1;
          state     <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (q_big) begin
            res <= neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            sat <= 1'b1;
          end else if (over_hi) begin
            res <= 32'sh7FFF_FFFF;
            sat <= 1'b1;
          end else if (over_lo) begin
            res <= 32'sh8000_0000;
            sat <= 1'b1;
          end else begin
            res <= sum36[31:0];
            sat <= 1'b0;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result register: hold while stalled, load when free
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      sample_value   <= res;
      interval_index <= j;
      saturated      <= sat;
    end
  end

  // Checks
  a_pop_needs_head: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue popped while empty");

  a_div_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (den != '0))
    else $error("divide started with zero denominator");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider finished outside the divide phase");

  a_interval_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (interval_index <= IDX_W'(KMAX - 2)))
    else $error("interval index beyond table");

endmodule

`default_nettype wire

[rtl/inverse_cdf_sampler.sv]
// Inverse-CDF sampler top level: configuration registers, front queue, back end.
// Depends on ics_pkg, ics_front, ics_back (which uses ics_ram and ics_div).
//
//   Channel   Handshake                 Payload
//   item      item_valid / item_stall   action, point_index, bin_value, cdf_value, uniform
//   result    result_valid/result_stall sample_value, interval_index, saturated
//   config    cfg_write                 cfg_index, cfg_data
//
// A load request is taken by the back end while idle and gives no result.
// A sample takes the back end through k CDF reads (k = points in use), one per
// cycle, two table reads and, if the denominator is positive, a two-pass 32x16
// multiply and a 64-step restoring divide, in that order, before its result is valid.
// Reset is synchronous; tables are not cleared, so no clearing pass is needed.
// A two-entry queue lets requests be taken while a result waits under stall.
`default_nettype none

module inverse_cdf_sampler #(
  parameter int MAX_POINTS = ics_pkg::MAX_POINTS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  item_valid,
  output logic                                       item_stall,
  input  wire logic                                  action,
  input  wire logic [ics_pkg::IDX_W-1:0]             point_index,
  input  wire logic signed [ics_pkg::EDGE_W-1:0]     bin_value,
  input  wire logic [ics_pkg::CDF_W-1:0]             cdf_value,
  input  wire logic [ics_pkg::UNI_W-1:0]             uniform,
  output logic                                       result_valid,
  input  wire logic                                  result_stall,
  output logic signed [ics_pkg::EDGE_W-1:0]          sample_value,
  output logic [ics_pkg::IDX_W-1:0]                  interval_index,
  output logic                                       saturated,
  input  wire logic                                  cfg_write,
  input  wire logic [ics_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [ics_pkg::CFG_DATA_W-1:0]        cfg_data
);

  import ics_pkg::*;

  cfg_t  cfg;
  item_t head;
  logic  head_valid;
  logic  pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.point_count <= POINT_COUNT_RST;
      cfg.epsilon     <= EPSILON_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_POINT_COUNT: cfg.point_count <= cfg_data[PC_W-1:0];
        REG_EPSILON:     cfg.epsilon     <= cfg_data[EPS_W-1:0];
        default:         cfg             <= cfg;
      endcase
    end
  end

  ics_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .action      (action),
    .point_index (point_index),
    .bin_value   (bin_value),
    .cdf_value   (cdf_value),
    .uniform     (uniform),
    .head        (head),
    .head_valid  (head_valid),
    .pop         (pop)
  );

  ics_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .head           (head),
    .head_valid     (head_valid),
    .pop            (pop),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .sample_value   (sample_value),
    .interval_index (interval_index),
    .saturated      (saturated)
  );

endmodule

`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for inverse_cdf_sampler: loads distribution tables, draws
// samples under random idling and compares each result with an interpolating predictor.
// Depends on ics_pkg and the sampler RTL.

module tb;
  import ics_pkg::*;

  localparam int     DEPTH           = MAX_POINTS_DEF;
  localparam int     SETTLE_CYCLES   = 200;
  localparam int     HOLD_OFF_CYCLES = 600;
  localparam int     PHASES          = 16;
  localparam int     DRAWS_PER_PHASE = 60;
  localparam int     REPORT_LIMIT    = 10;
  localparam longint S32_MAX         = 64'sd2147483647;
  localparam longint S32_MIN         = -64'sd2147483648;
  localparam longint U31_MAX         = 64'sd2147483647;
  localparam longint QUOT_LIMIT      = 64'sd17179869184;

  typedef struct {
    logic signed [EDGE_W-1:0] value;
    logic [IDX_W-1:0]         interval;
    logic                     sat;
  } drawn_sample_t;

  typedef enum int {PLAN_RISING, PLAN_FLAT, PLAN_NOISE} plan_kind_t;

  // Own copy of the tables and registers; one expected sample per sample request
  class sampler_scoreboard;
    logic [CDF_W-1:0]         cdf_copy [DEPTH];
    logic signed [EDGE_W-1:0] edge_copy [DEPTH];
    logic [PC_W-1:0]          count_reg;
    logic [EPS_W-1:0]         eps_reg;
    drawn_sample_t            awaited_samples [$];
    int                       failures;

    function new();
      count_reg = POINT_COUNT_RST;
      eps_reg   = EPSILON_RST;
      failures  = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_POINT_COUNT) count_reg = data[PC_W-1:0];
      else if (idx == REG_EPSILON) eps_reg = data[EPS_W-1:0];
    endfunction

    // Locate the interval for u, then interpolate between the edges that bound it
    function drawn_sample_t interpolate_sample(logic [UNI_W-1:0] u);
      drawn_sample_t s;
      int            k, hits, j;
      longint        c0, c1, e0, e1, den, diff, du, res, uval, eps_l;
      bit [63:0]     mag_diff, mag_du, q;
      bit            neg;
      k = int'(count_reg);
      if (k < 2) k = 2;
      if (k > DEPTH) k = DEPTH;
      hits = 0;
      for (int t = 0; t < k; t++)
        if ({1'b0, u} >= cdf_copy[t]) hits++;
      j = (hits == 0) ? 0 : hits - 1;
      if (j > k - 2) j = k - 2;
      c0    = cdf_copy[j];
      c1    = cdf_copy[j + 1];
      e0    = edge_copy[j];
      e1    = edge_copy[j + 1];
      eps_l = eps_reg;
      uval  = u;
      den   = c1 - c0 + eps_l;
      s.sat = 1'b0;
      if (den <= 0) begin
        // no usable slope: return the left edge
        res   = e0;
        s.sat = 1'b1;
      end else begin
        diff     = e1 - e0;
        du       = uval - c0;
        neg      = (diff < 0) != (du < 0);
        mag_diff = (diff < 0) ? -diff : diff;
        mag_du   = (du < 0) ? -du : du;
        q        = (mag_diff * mag_du) / den;
        if (q > QUOT_LIMIT) begin
          res   = neg ? S32_MIN : S32_MAX;
          s.sat = 1'b1;
        end else begin
          res = neg ? e0 - longint'(q) : e0 + longint'(q);
          if (res > S32_MAX) begin
            res   = S32_MAX;
            s.sat = 1'b1;
          end
          if (res < S32_MIN) begin
            res   = S32_MIN;
            s.sat = 1'b1;
          end
        end
      end
      s.value    = res[31:0];
      s.interval = j[IDX_W-1:0];
      return s;
    endfunction

    function void note_request(logic act, logic [IDX_W-1:0] idx,
                               logic signed [EDGE_W-1:0] bin, logic [CDF_W-1:0] cdf,
                               logic [UNI_W-1:0] u);
      if (act == ACT_SAMPLE) begin
        awaited_samples.push_back(interpolate_sample(u));
      end else if (idx < DEPTH) begin
        edge_copy[idx] = bin;
        cdf_copy[idx]  = cdf;
      end
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= REPORT_LIMIT) $display("%s", msg);
    endfunction

    function void check_result(logic signed [EDGE_W-1:0] value, logic [IDX_W-1:0] interval,
                               logic sat);
      drawn_sample_t want;
      if (awaited_samples.size() == 0) begin
        note_failure($sformatf("unexpected result: value %0d interval %0d saturated %0b",
                               value, interval, sat));
        return;
      end
      want = awaited_samples.pop_front();
      if (value !== want.value || interval !== want.interval || sat !== want.sat)
        note_failure($sformatf(
          "sample mismatch: expected value %0d interval %0d saturated %0b, got %0d %0d %0b",
          want.value, want.interval, want.sat, value, interval, sat));
    endfunction

    function int outstanding();
      return awaited_samples.size();
    endfunction
  endclass

  logic                     clk            = 1'b0;
  logic                     rst            = 1'b1;
  logic                     item_valid     = 1'b0;
  logic                     item_stall;
  logic                     action         = ACT_LOAD;
  logic [IDX_W-1:0]         point_index    = '0;
  logic signed [EDGE_W-1:0] bin_value      = '0;
  logic [CDF_W-1:0]         cdf_value      = '0;
  logic [UNI_W-1:0]         uniform        = '0;
  logic                     result_valid;
  logic                     result_stall   = 1'b0;
  logic signed [EDGE_W-1:0] sample_value;
  logic [IDX_W-1:0]         interval_index;
  logic                     saturated;
  logic                     cfg_write      = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index      = '0;
  logic [CFG_DATA_W-1:0]    cfg_data       = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_off_left  = 0;

  // Table contents as last loaded, used to aim uniform values at real intervals
  logic [CDF_W-1:0]         plan_cdf [DEPTH];
  logic signed [EDGE_W-1:0] plan_edge [DEPTH];

  sampler_scoreboard sb = new();

  inverse_cdf_sampler u_top (.*);

  always #4 clk = ~clk;

  // Observe accepted config writes, results and requests; results first
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_write) sb.write_register(cfg_index, cfg_data);
      if (result_valid && !result_stall)
        sb.check_result(sample_value, interval_index, saturated);
      if (item_valid && !item_stall)
        sb.note_request(action, point_index, bin_value, cdf_value, uniform);
    end
  end

  // Stall the result channel: long hold-off when requested, random otherwise
  always @(posedge clk) begin
    if (hold_off_left > 0) begin
      result_stall  <= 1'b1;
      hold_off_left <= hold_off_left - 1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Offer one request, with random gaps ahead of it, and hold it until taken
  task automatic send_request(logic act, logic [IDX_W-1:0] idx, logic signed [EDGE_W-1:0] bin,
                              logic [CDF_W-1:0] cdf, logic [UNI_W-1:0] u);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid  <= 1'b1;
    action      <= act;
    point_index <= idx;
    bin_value   <= bin;
    cdf_value   <= cdf;
    uniform     <= u;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  task automatic load_point(int idx, logic signed [EDGE_W-1:0] edge_val,
                            logic [CDF_W-1:0] cdf_val);
    plan_edge[idx] = edge_val;
    plan_cdf[idx]  = cdf_val;
    send_request(ACT_LOAD, IDX_W'(idx), edge_val, cdf_val, UNI_W'($urandom()));
  endtask

  task automatic draw_sample(logic [UNI_W-1:0] u);
    send_request(ACT_SAMPLE, IDX_W'($urandom()), $urandom(), $urandom(), u);
  endtask

  // Drain all expected samples, then let trailing loads finish
  task automatic wait_idle();
    item_valid <= 1'b0;
    // let the monitor note the last accepted request first
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_config(int pc, int eps);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_index <= REG_POINT_COUNT;
    cfg_data  <= CFG_DATA_W'(pc);
    @(posedge clk);
    cfg_index <= REG_EPSILON;
    cfg_data  <= CFG_DATA_W'(eps);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic int points_in_use(int pc);
    if (pc < 2) return 2;
    if (pc > DEPTH) return DEPTH;
    return pc;
  endfunction

  // Build and load the first n table points with the given profile
  task automatic load_profile(plan_kind_t kind, int n);
    longint      level, edge_pos;
    int unsigned step_max;
    level    = $urandom_range(1 << 26, 0);
    edge_pos = $urandom();
    step_max = 32'hFFFF_FFFF / n;
    for (int i = 0; i < n; i++) begin
      case (kind)
        PLAN_RISING: begin
          level    += $urandom_range(step_max, 0);
          edge_pos += $urandom_range(1 << 22, 0);
        end
        PLAN_FLAT: begin
          // repeated CDF levels half the time, else a rise or a drop
          case ($urandom_range(3))
            0, 1: begin end
            2: level += $urandom_range(step_max, 0);
            default: level -= $urandom_range(step_max / 4, 0);
          endcase
          edge_pos += $urandom_range(1 << 22, 0);
        end
        default: begin
          level    = $urandom();
          edge_pos = $urandom();
        end
      endcase
      if (level < 0) level = 0;
      if (level > 64'sh0_FFFF_FFFF) level = 64'sh0_FFFF_FFFF;
      load_point(i, edge_pos[31:0], level[31:0]);
    end
  endtask

  // Aim mostly inside an interval of the table, sometimes at a point or anywhere
  function automatic logic [UNI_W-1:0] pick_uniform(int n);
    int     i;
    longint lo, hi, tmp;
    i  = $urandom_range(n - 2, 0);
    lo = plan_cdf[i];
    hi = plan_cdf[i + 1];
    if (lo > hi) begin
      tmp = lo;
      lo  = hi;
      hi  = tmp;
    end
    if (hi > U31_MAX) hi = U31_MAX;
    if (lo > U31_MAX) lo = U31_MAX;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return UNI_W'($urandom_range(32'(hi), 32'(lo)));
      6, 7: return UNI_W'(lo);
      default: return UNI_W'($urandom());
    endcase
  endfunction

  initial begin
    int         pc, eps, n;
    plan_kind_t kind;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Fill the whole table: linear edges over the full range, last CDF above any u
    for (int i = 0; i < DEPTH; i++)
      load_point(i, EDGE_W'((i == DEPTH - 1) ? S32_MAX : S32_MIN + longint'(i) * 68174084),
                 (i == DEPTH - 1) ? 32'hFFFF_FFFF : i * 34087042);

    // Reset configuration: both uniform extremes, an exact CDF point, a middle value
    draw_sample('0);
    draw_sample('1);
    draw_sample(UNI_W'(20 * 34087042));
    draw_sample(UNI_W'(1000000000));

    // Count below range and zero epsilon: flat and falling CDF give no slope
    apply_config(0, 0);
    load_point(0, 0, 100);
    load_point(1, 1000, 100);
    draw_sample(UNI_W'(50));
    draw_sample(UNI_W'(100));
    load_point(1, 1000, 40);
    draw_sample(UNI_W'(100));

    // Count above range and largest epsilon
    apply_config(127, 65535);
    load_point(0, EDGE_W'(S32_MIN), 0);
    load_point(1, EDGE_W'(S32_MIN + 68174084), 34087042);
    draw_sample('1);
    draw_sample(UNI_W'(12345));

    // Two points, steep slopes: overflow in both directions
    apply_config(1, 1);
    load_point(0, 0, 0);
    load_point(1, EDGE_W'(S32_MAX), 1);
    draw_sample('1);
    load_point(1, EDGE_W'(S32_MIN), 1);
    draw_sample('1);
    load_point(0, EDGE_W'(S32_MIN), 32'h7000_0000);
    load_point(1, EDGE_W'(S32_MAX), 32'hFFFF_FFFF);
    draw_sample('0);

    // Random phases over configurations, table profiles and idling patterns
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: pc = 64;
        1: pc = 2;
        2: pc = 127;
        3: pc = 1;
        default: pc = $urandom_range(1) ? $urandom_range(12, 2) : $urandom_range(64, 2);
      endcase
      if (p == 6) eps = 0;
      else if (p % 5 == 0) eps = 65535;
      else if (p % 5 == 1) eps = 1;
      else eps = $urandom_range(65535, 1);
      case ($urandom_range(19)) inside
        [0:11]: kind = PLAN_RISING;
        [12:16]: kind = PLAN_FLAT;
        default: kind = PLAN_NOISE;
      endcase
      if (p == 6) kind = PLAN_FLAT;

      apply_config(pc, eps);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      n = points_in_use(pc);
      load_profile(kind, n);

      // Back up the block once with a long result hold-off
      if (p == 4) hold_off_left = HOLD_OFF_CYCLES;

      repeat (DRAWS_PER_PHASE) begin
        if ($urandom_range(19) == 0)
          load_point($urandom_range(DEPTH - 1), $urandom(), $urandom());
        else
          draw_sample(pick_uniform(n));
      end
    end

    wait_idle();
    if (sb.failures == 0 && sb.outstanding() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // Hard stop if the block hangs
  initial begin
    #16000000;
    $display("Verification failed");
    $finish;
  end

endmodule

[sim.f]
rtl/ics_pkg.sv
rtl/ics_ram.sv
rtl/ics_front.sv
rtl/ics_div.sv
rtl/ics_back.sv
rtl/inverse_cdf_sampler.sv
bench/tb.sv
